// ===== sv/ptml_pkg.sv =====
// Package for the path time mark locator.
// Holds sizes, status and mode codes and the result beat type.
// Used by the top level and the testbench.
package ptml_pkg;
    localparam int MaxPoints = 128;
    localparam int AddrW     = $clog2(MaxPoints);
    localparam int CountW    = AddrW + 1;
    localparam int MarkW     = 32;

    typedef enum logic [1:0] {
        t_MODE_START  = 2'd0,
        t_MODE_APPEND = 2'd1,
        t_MODE_LOCATE = 2'd2,
        t_MODE_NONE   = 2'd3
    } t_mode;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StSpeed = 2'd1;
    localparam logic [1:0] StFull  = 2'd2;
    localparam logic [1:0] StFew   = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] segment_length;
        logic [31:0] elapsed;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  segment_index;
        logic [16:0] fraction;
        logic [31:0] total_ms;
    } t_out_beat;
endpackage

// ===== sv/ptml_in_if.sv =====
// Input channel interface: valid, ready and the input beat.
// Standalone; widths follow ptml_pkg.
interface ptml_in_if;
    logic valid;
    logic ready;
    logic [1:0]  mode;
    logic [23:0] segment_length;
    logic [31:0] elapsed;
    modport source (output valid, mode, segment_length, elapsed, input ready);
    modport sink   (input valid, mode, segment_length, elapsed, output ready);
endinterface

// ===== sv/ptml_out_if.sv =====
// Output channel interface: valid, ready and the result beat.
// Standalone; widths follow ptml_pkg.
interface ptml_out_if;
    logic valid;
    logic ready;
    logic [1:0]  status;
    logic [6:0]  segment_index;
    logic [16:0] fraction;
    logic [31:0] total_ms;
    modport source (output valid, status, segment_index, fraction, total_ms, input ready);
    modport sink   (input valid, status, segment_index, fraction, total_ms, output ready);
endinterface

// ===== sv/path_time_mark_locator.sv =====
// Path time mark locator: cumulative millisecond marks of one path in one RAM.
// A start beat goes straight to the finish state; all other beats first read the
// last mark. Error and mode-3 beats then finish, an append divides with the divider,
// and a locate clamps or runs at most 8 binary-search steps and divides the span.
// One item is in work at a time; the output register holds a waiting result.
// Synchronous reset clears the mark count, speed and result valid.
module path_time_mark_locator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    ptml_in_if.sink     i_in,
    ptml_out_if.source  o_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_LAST, S_APPDIV, S_FIRST, S_SRCH, S_SRCHRD, S_FROM, S_TO,
        S_SPAN, S_FRDIV, S_FIN
    } t_state;

    t_state                      r_state;
    logic [15:0]                 r_speed;
    logic [ptml_pkg::CountW-1:0] r_count;
    logic [ptml_pkg::MarkW-1:0]  r_last, r_from, r_t;
    ptml_pkg::t_mode             r_mode;
    logic [23:0]                 r_len;
    logic [ptml_pkg::CountW-1:0] r_lo, r_hi;
    logic [ptml_pkg::AddrW-1:0]  r_seg;
    ptml_pkg::t_out_beat         r_res;
    ptml_pkg::t_out_beat         r_obeat;
    logic                        r_ovalid;

    logic                        ram_we;
    logic [ptml_pkg::AddrW-1:0]  ram_waddr, ram_raddr;
    logic [ptml_pkg::MarkW-1:0]  ram_wdata, ram_rdata;
    logic                        div_start, div_done;
    logic [47:0]                 div_num, div_quot;
    logic [31:0]                 div_den;
    logic [ptml_pkg::CountW-1:0] mid;
    logic [32:0]                 sum;
    logic [31:0]                 new_mark;
    logic                        app_go;
    logic                        accept;
    logic                        res_free;

    ptml_ram #(.Width(ptml_pkg::MarkW), .Depth(ptml_pkg::MaxPoints)) u_marks (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    ptml_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quot(div_quot)
    );

    // Handshakes, search midpoint and the saturated next mark.
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && (r_state == S_IDLE);
    assign res_free   = !r_ovalid || o_out.ready;
    assign mid        = r_lo + ((r_hi - r_lo) >> 1);
    assign sum        = {1'b0, r_last} + {1'b0, div_quot[31:0]};
    assign new_mark   = (sum[32] || (div_quot[47:32] != 16'd0)) ? 32'hFFFF_FFFF : sum[31:0];
    assign app_go     = (r_speed != 16'd0) && (r_count != '0) &&
                        (r_count < ptml_pkg::CountW'(ptml_pkg::MaxPoints));

    // RAM address, write control and divider requests per state.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[ptml_pkg::AddrW-1:0];
        ram_wdata = new_mark;
        ram_raddr = '0;
        div_start = 1'b0;
        div_num   = {r_t - r_from, 16'd0};
        div_den   = ram_rdata - r_from;
        unique case (r_state)
            S_IDLE: begin
                ram_raddr = ptml_pkg::AddrW'(r_count - ptml_pkg::CountW'(1));
                if (accept && i_in.mode == ptml_pkg::t_MODE_START && r_speed != 16'd0) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = 32'd1;
                end
            end
            S_LAST: begin
                if (r_mode == ptml_pkg::t_MODE_APPEND && app_go) begin
                    div_start = 1'b1;
                    div_num   = 48'(r_len) * 48'd1000;
                    div_den   = {16'd0, r_speed};
                end
            end
            S_APPDIV: ram_we = div_done;
            S_SRCH:   ram_raddr = mid[ptml_pkg::AddrW-1:0];
            S_FROM:   ram_raddr = r_seg;
            S_TO:     ram_raddr = r_seg + ptml_pkg::AddrW'(1);
            // The next mark is on the read port; divide only a nonzero span.
            S_SPAN:   div_start = (ram_rdata > r_from);
            default:  ;
        endcase
    end

    // Main sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_speed  <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_speed <= i_cfg_wdata;
            end
            // The finish state always leaves a beat in the result register.
            if (r_state == S_FIN) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_FIN && res_free) begin
                r_obeat <= r_res;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_mode <= ptml_pkg::t_mode'(i_in.mode);
                        r_len  <= i_in.segment_length;
                        r_t    <= i_in.elapsed;
                        if (i_in.mode == ptml_pkg::t_MODE_START) begin
                            r_count <= (r_speed != 16'd0) ? ptml_pkg::CountW'(1) : '0;
                            r_res.status <= (r_speed != 16'd0) ? ptml_pkg::StOk
                                                               : ptml_pkg::StSpeed;
                            r_res.segment_index <= '0;
                            r_res.fraction      <= '0;
                            r_res.total_ms      <= (r_speed != 16'd0) ? 32'd1 : 32'd0;
                            r_state <= S_FIN;
                        end else begin
                            r_res   <= '0;
                            r_state <= S_LAST;
                        end
                    end
                end
                S_LAST: begin
                    r_last         <= (r_count == '0) ? 32'd0 : ram_rdata;
                    r_res.total_ms <= (r_count == '0) ? 32'd0 : ram_rdata;
                    unique case (r_mode)
                        ptml_pkg::t_MODE_APPEND: begin
                            if (app_go) begin
                                r_state <= S_APPDIV;
                            end else begin
                                priority if (r_speed == 16'd0) begin
                                    r_res.status <= ptml_pkg::StSpeed;
                                end else if (r_count == '0) begin
                                    r_res.status <= ptml_pkg::StFew;
                                end else begin
                                    r_res.status <= ptml_pkg::StFull;
                                end
                                r_state <= S_FIN;
                            end
                        end
                        ptml_pkg::t_MODE_LOCATE: begin
                            if (r_count < ptml_pkg::CountW'(2)) begin
                                r_res.status <= ptml_pkg::StFew;
                                r_state      <= S_FIN;
                            end else begin
                                r_state <= S_FIRST;
                            end
                        end
                        ptml_pkg::t_MODE_START, ptml_pkg::t_MODE_NONE: r_state <= S_FIN;
                    endcase
                end
                S_APPDIV: begin
                    if (div_done) begin
                        r_res.total_ms <= new_mark;
                        r_count        <= r_count + ptml_pkg::CountW'(1);
                        r_state        <= S_FIN;
                    end
                end
                S_FIRST: begin
                    // The read port holds the first mark.
                    r_lo <= '0;
                    r_hi <= r_count;
                    if (r_t <= ram_rdata) begin
                        r_state <= S_FIN;
                    end else if (r_t >= r_last) begin
                        r_res.segment_index <= 7'(r_count - ptml_pkg::CountW'(2));
                        r_res.fraction      <= 17'h10000;
                        r_state             <= S_FIN;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_state <= S_SRCHRD;
                    end else begin
                        r_seg   <= ptml_pkg::AddrW'(r_lo - ptml_pkg::CountW'(1));
                        r_state <= S_FROM;
                    end
                end
                S_SRCHRD: begin
                    if (ram_rdata > r_t) begin
                        r_hi <= mid;
                    end else begin
                        r_lo <= mid + ptml_pkg::CountW'(1);
                    end
                    r_state <= S_SRCH;
                end
                S_FROM: r_state <= S_TO;
                S_TO: begin
                    r_from  <= ram_rdata;
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    if (ram_rdata > r_from) begin
                        r_state <= S_FRDIV;
                    end else begin
                        r_res.segment_index <= 7'(r_seg);
                        r_res.fraction      <= 17'h10000;
                        r_state             <= S_FIN;
                    end
                end
                S_FRDIV: begin
                    if (div_done) begin
                        r_res.segment_index <= 7'(r_seg);
                        r_res.fraction <= (div_quot > 48'h10000) ? 17'h10000 : div_quot[16:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (res_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.status        = r_obeat.status;
    assign o_out.segment_index = r_obeat.segment_index;
    assign o_out.fraction      = r_obeat.fraction;
    assign o_out.total_ms      = r_obeat.total_ms;

    // A waiting result beat holds still until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(r_obeat));

    // The mark count never passes the table size.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ptml_pkg::CountW'(ptml_pkg::MaxPoints));

    // The fraction never exceeds one.
    a_frac_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.fraction <= 17'h10000);

    // An error beat carries no segment and no fraction.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != ptml_pkg::StOk |->
            o_out.segment_index == '0 && o_out.fraction == '0);
endmodule

// ===== sv/ptml_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ptml_ram #(
    parameter int Width = 32,
    parameter int Depth = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/ptml_div.sv =====
// Restoring divider, one quotient bit per cycle, 48-bit dividend.
// Depends on no package; used by the top level for both divisions.
module ptml_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quot
);
    logic [47:0] r_quot;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] n_trial;
    logic [32:0] n_shift;

    // One trial subtraction per cycle.
    always_comb begin
        n_shift = {r_rem[31:0], r_quot[47]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= 6'd47;
            end else if (r_busy) begin
                if (!n_trial[32]) begin
                    r_rem  <= n_trial;
                    r_quot <= {r_quot[46:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_quot <= {r_quot[46:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_quot;
endmodule

// ===== verif/tb_path_time_mark_locator.sv =====
// Testbench for the path time mark locator: directed and random beats checked
// against an in-bench predictor of the mark table. Depends on ptml_pkg,
// ptml_in_if, ptml_out_if and path_time_mark_locator.
`timescale 1ns / 100ps

module tb_path_time_mark_locator;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    ptml_in_if  in_ch();
    ptml_out_if out_ch();

    path_time_mark_locator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: a private copy of the mark table and speed.
    logic [31:0] mark_tab [ptml_pkg::MaxPoints];
    int unsigned mark_num;
    logic [15:0] cur_speed;
    ptml_pkg::t_out_beat pending_results[$];
    int          fail_cnt = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    function automatic logic [31:0] tail_mark();
        return (mark_num == 0) ? 32'd0 : mark_tab[mark_num - 1];
    endfunction

    // Works out the result of one beat and advances the table.
    function automatic ptml_pkg::t_out_beat locate_step(ptml_pkg::t_mode md,
                                                        logic [23:0] len, logic [31:0] t);
        ptml_pkg::t_out_beat r;
        logic [63:0] sum;
        logic [63:0] q;
        int unsigned lo, hi, mid, seg;
        r = '0;
        case (md)
            ptml_pkg::t_MODE_START: begin
                mark_num = 0;
                if (cur_speed == 0) begin
                    r.status = ptml_pkg::StSpeed;
                end else begin
                    mark_tab[0] = 32'd1;
                    mark_num = 1;
                end
            end
            ptml_pkg::t_MODE_APPEND: begin
                if (cur_speed == 0) r.status = ptml_pkg::StSpeed;
                else if (mark_num == 0) r.status = ptml_pkg::StFew;
                else if (mark_num >= ptml_pkg::MaxPoints) r.status = ptml_pkg::StFull;
                else begin
                    sum = {32'd0, mark_tab[mark_num - 1]}
                        + ({40'd0, len} * 64'd1000) / {48'd0, cur_speed};
                    mark_tab[mark_num] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                    mark_num++;
                end
            end
            ptml_pkg::t_MODE_LOCATE: begin
                if (mark_num < 2) begin
                    r.status = ptml_pkg::StFew;
                end else if (t <= mark_tab[0]) begin
                    r.status = ptml_pkg::StOk;
                end else if (t >= mark_tab[mark_num - 1]) begin
                    r.segment_index = 7'(mark_num - 2);
                    r.fraction = 17'd65536;
                end else begin
                    lo = 0;
                    hi = mark_num;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (mark_tab[mid] > t) hi = mid;
                        else lo = mid + 1;
                    end
                    seg = (lo >= 1) ? lo - 1 : 0;
                    if (seg > mark_num - 2) seg = mark_num - 2;
                    r.segment_index = 7'(seg);
                    if (mark_tab[seg + 1] > mark_tab[seg] && t >= mark_tab[seg]) begin
                        q = ({32'd0, t - mark_tab[seg]} << 16)
                            / {32'd0, mark_tab[seg + 1] - mark_tab[seg]};
                        r.fraction = (q > 64'd65536) ? 17'd65536 : q[16:0];
                    end else begin
                        r.fraction = 17'd65536;
                    end
                end
            end
            default: ;
        endcase
        r.total_ms = tail_mark();
        return r;
    endfunction

    // Sends one beat, then predicts its result once accepted. Valid stays
    // high into the next call; idle cycles and draining drop it.
    task automatic send_beat(ptml_pkg::t_mode md, logic [23:0] len, logic [31:0] t);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= md;
        in_ch.segment_length <= len;
        in_ch.elapsed <= t;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.insert(pending_results.size(), locate_step(md, len, t));
        @(negedge i_clk);
    endtask

    // Waits until all results are in, plus the block's tail latency.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_speed(logic [15:0] v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_speed = v;
    endtask

    // Result checker: compares each accepted beat with the oldest prediction.
    always @(posedge i_clk) begin
        ptml_pkg::t_out_beat want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected beat status=%0d seg=%0d frac=%0d total=%0d",
                    $time, out_ch.status, out_ch.segment_index, out_ch.fraction,
                    out_ch.total_ms);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.status !== want.status ||
                    out_ch.segment_index !== want.segment_index ||
                    out_ch.fraction !== want.fraction ||
                    out_ch.total_ms !== want.total_ms) begin
                    $display("%0t: expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
                        $time, want.status, want.segment_index, want.fraction,
                        want.total_ms, out_ch.status, out_ch.segment_index,
                        out_ch.fraction, out_ch.total_ms);
                    fail_cnt++;
                end
            end
        end
    end

    // Receiver stalls at the falling edge.
    always @(negedge i_clk)
        out_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);

    task automatic test_errors_and_edges();
        send_beat(ptml_pkg::t_MODE_LOCATE, 24'd0, 32'd5);
        send_beat(ptml_pkg::t_MODE_APPEND, 24'd10, 32'd0);
        send_beat(ptml_pkg::t_MODE_START, 24'd0, 32'd0);
        send_beat(ptml_pkg::t_MODE_NONE, 24'hFFFFFF, 32'hFFFF_FFFF);
        write_speed(16'hFFFF);
        send_beat(ptml_pkg::t_MODE_APPEND, 24'd5, 32'd0);
        send_beat(ptml_pkg::t_MODE_START, 24'd0, 32'd0);
        send_beat(ptml_pkg::t_MODE_LOCATE, 24'd0, 32'd5);
        send_beat(ptml_pkg::t_MODE_APPEND, 24'd0, 32'd0);
        send_beat(ptml_pkg::t_MODE_APPEND, 24'hFFFFFF, 32'd0);
        send_beat(ptml_pkg::t_MODE_APPEND, 24'd1000, 32'd0);
        send_beat(ptml_pkg::t_MODE_LOCATE, 24'd0, 32'd0);
        send_beat(ptml_pkg::t_MODE_LOCATE, 24'd0, 32'd1);
        send_beat(ptml_pkg::t_MODE_LOCATE, 24'd0, 32'd2);
        send_beat(ptml_pkg::t_MODE_LOCATE, 24'd0, tail_mark() - 32'd1);
        send_beat(ptml_pkg::t_MODE_LOCATE, 24'd0, 32'hFFFF_FFFF);
        send_beat(ptml_pkg::t_MODE_NONE, 24'd0, 32'd0);
        write_speed(16'd1);
        send_beat(ptml_pkg::t_MODE_START, 24'd0, 32'd0);
        repeat (3) send_beat(ptml_pkg::t_MODE_APPEND, 24'hFFFFFF, 32'd0);
        send_beat(ptml_pkg::t_MODE_LOCATE, 24'd0, 32'hFFFF_FFFE);
        write_speed(16'd0);
        send_beat(ptml_pkg::t_MODE_APPEND, 24'd1, 32'd0);
        send_beat(ptml_pkg::t_MODE_START, 24'd0, 32'd0);
    endtask

    task automatic test_full_table();
        write_speed(16'd256);
        send_beat(ptml_pkg::t_MODE_START, 24'd0, 32'd0);
        for (int i = 0; i < ptml_pkg::MaxPoints; i++)
            send_beat(ptml_pkg::t_MODE_APPEND, 24'($urandom_range(2000)), 32'd0);
        send_beat(ptml_pkg::t_MODE_LOCATE, 24'd0, 32'($urandom_range(tail_mark())));
    endtask

    // Random paths: mostly a start, appends, then six locates.
    task automatic test_random_paths(int unsigned n_beats);
        int unsigned sent = 0;
        int unsigned n_seg;
        ptml_pkg::t_mode md;
        while (sent < n_beats) begin
            if ($urandom_range(9) == 0) begin
                md = ptml_pkg::t_mode'($urandom_range(3));
                send_beat(md, 24'($urandom), $urandom);
                sent++;
            end else begin
                send_beat(ptml_pkg::t_MODE_START, 24'($urandom), $urandom);
                n_seg = ($urandom_range(7) == 0) ? $urandom_range(130) : $urandom_range(12);
                for (int i = 0; i < n_seg; i++) begin
                    send_beat(ptml_pkg::t_MODE_APPEND, ($urandom_range(3) == 0)
                        ? 24'($urandom) : 24'($urandom_range(4000)), $urandom);
                end
                for (int i = 0; i < 6; i++) begin
                    send_beat(ptml_pkg::t_MODE_LOCATE, 24'($urandom),
                        ($urandom_range(4) == 0) ? $urandom
                                                 : 32'($urandom_range(tail_mark() + 2)));
                end
                sent += n_seg + 7;
            end
        end
    endtask

    task automatic test_idle_phases();
        write_speed(16'($urandom_range(1, 65535)));
        send_idle_pct = 84; recv_stall_pct = 0;
        test_random_paths(120);
        send_idle_pct = 0; recv_stall_pct = 84;
        test_random_paths(120);
        // Hold off until the block has emptied, then go on.
        drain_results();
        send_idle_pct = 8; recv_stall_pct = 8;
        write_speed(16'($urandom_range(1, 300)));
        test_random_paths(120);
        send_idle_pct = 0; recv_stall_pct = 0;
        write_speed(16'hFFFF);
        test_random_paths(100);
        write_speed(16'd1);
        test_random_paths(80);
    endtask

    initial begin
        mark_num = 0;
        cur_speed = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.segment_length = '0;
        in_ch.elapsed = '0;
        out_ch.ready = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_errors_and_edges();
        test_full_table();
        test_random_paths(60);
        test_idle_phases();
        drain_results();
        if (fail_cnt == 0 && pending_results.size() == 0)
            $display("** path_time_mark_locator: PASSED **");
        else
            $display("** path_time_mark_locator: FAILED **");
        $finish;
    end

    initial begin
        #2000000;
        $display("** path_time_mark_locator: FAILED **");
        $finish;
    end
endmodule
